[src/mhpq_pkg.sv]
// mhpq_pkg: shared types and codes for the max-heap priority queue
// used by mhpq_ctrl, mhpq_dp and max_heap_priority_queue; depends on nothing

package mhpq_pkg;

    localparam int DATA_W  = 32;
    localparam int COUNT_W = 8;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_INS,
        OP_REM,
        OP_REJECT,
        OP_UP_READ,
        OP_UP_MOVE,
        OP_LAST_LOAD,
        OP_DN_READ,
        OP_DN_LEFT,
        OP_DN_RIGHT,
        OP_PLACE
    } op_t;

    typedef struct packed {
        op_t     op;
        logic    respond;
        status_t code;
    } ctrl_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic full;
        logic at_root;
        logic val_gt_parent;
        logic leaf;
        logic left_wins;
        logic right_wins;
    } dp_stat_t;

endpackage

[src/max_heap_priority_queue.sv]
// max_heap_priority_queue: top level of the binary max-heap priority queue
// depends on mhpq_pkg, mhpq_ctrl, mhpq_dp (and mhpq_ram through it)

// One request at a time: a request is taken when start is high and busy is low,
// and its result appears for exactly one cycle with done high; the receiver
// cannot stall it. The heap lives in a single memory with registered reads, so
// each level walked takes a read, then a compare and write. A rejected request
// is answered without leaving idle. An insert climbs from the new last slot
// toward the root; a removal takes the root and sifts the last entry down from
// the root, or ends at once when it empties the heap. A new start is taken in
// the cycle done is high.

module max_heap_priority_queue #(
    parameter int CAPACITY = 128
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               req_type,
    input  logic signed [mhpq_pkg::DATA_W-1:0] value,
    output logic                               done,
    output logic [1:0]                         status,
    output logic signed [mhpq_pkg::DATA_W-1:0] removed_value,
    output logic [mhpq_pkg::COUNT_W-1:0]       entry_count,
    output logic signed [mhpq_pkg::DATA_W-1:0] max_value
);

    mhpq_pkg::ctrl_cmd_t cmd;
    mhpq_pkg::dp_stat_t  stat;

    mhpq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .stat     (stat),
        .busy     (busy),
        .cmd      (cmd)
    );

    mhpq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .value         (value),
        .cmd           (cmd),
        .stat          (stat),
        .done          (done),
        .status        (status),
        .removed_value (removed_value),
        .entry_count   (entry_count),
        .max_value     (max_value)
    );

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobed while still busy");

    a_empty_remove: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req_type == mhpq_pkg::REQ_REMOVE) && stat.count_zero)
        |=> (done && (status == mhpq_pkg::STAT_EMPTY)))
        else $error("removal from empty heap not rejected at once");

endmodule

[src/mhpq_ram.sv]
// mhpq_ram: generic single-write, dual-read memory with registered read data
// no dependencies

module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

[src/mhpq_ctrl.sv]
// mhpq_ctrl: request sequencer for the heap, issues datapath commands
// depends on mhpq_pkg

module mhpq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                req_type,
    input  mhpq_pkg::dp_stat_t  stat,
    output logic                busy,
    output mhpq_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_UP_ISSUE = 6'b000010,
        S_UP_CMP   = 6'b000100,
        S_LAST     = 6'b001000,
        S_DN_ISSUE = 6'b010000,
        S_DN_CMP   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        cmd.op      = mhpq_pkg::OP_NONE;
        cmd.respond = 1'b0;
        cmd.code    = mhpq_pkg::STAT_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (req_type == mhpq_pkg::REQ_INSERT)
                    begin
                        if (stat.full)
                        begin
                            cmd.op      = mhpq_pkg::OP_REJECT;
                            cmd.respond = 1'b1;
                            cmd.code    = mhpq_pkg::STAT_FULL;
                        end
                        else
                        begin
                            cmd.op     = mhpq_pkg::OP_INS;
                            state_next = S_UP_ISSUE;
                        end
                    end
                    else
                    begin
                        if (stat.count_zero)
                        begin
                            cmd.op      = mhpq_pkg::OP_REJECT;
                            cmd.respond = 1'b1;
                            cmd.code    = mhpq_pkg::STAT_EMPTY;
                        end
                        else
                        begin
                            cmd.op     = mhpq_pkg::OP_REM;
                            state_next = S_LAST;
                        end
                    end
                end
            end
            S_UP_ISSUE:
            begin
                if (stat.at_root)
                begin
                    cmd.op      = mhpq_pkg::OP_PLACE;
                    cmd.respond = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    cmd.op     = mhpq_pkg::OP_UP_READ;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                if (stat.val_gt_parent)
                begin
                    cmd.op     = mhpq_pkg::OP_UP_MOVE;
                    state_next = S_UP_ISSUE;
                end
                else
                begin
                    cmd.op      = mhpq_pkg::OP_PLACE;
                    cmd.respond = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_LAST:
            begin
                if (stat.count_zero)
                begin
                    cmd.respond = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    cmd.op     = mhpq_pkg::OP_LAST_LOAD;
                    state_next = S_DN_ISSUE;
                end
            end
            S_DN_ISSUE:
            begin
                if (stat.leaf)
                begin
                    cmd.op      = mhpq_pkg::OP_PLACE;
                    cmd.respond = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    cmd.op     = mhpq_pkg::OP_DN_READ;
                    state_next = S_DN_CMP;
                end
            end
            S_DN_CMP:
            begin
                if (stat.right_wins)
                begin
                    cmd.op     = mhpq_pkg::OP_DN_RIGHT;
                    state_next = S_DN_ISSUE;
                end
                else if (stat.left_wins)
                begin
                    cmd.op     = mhpq_pkg::OP_DN_LEFT;
                    state_next = S_DN_ISSUE;
                end
                else
                begin
                    cmd.op      = mhpq_pkg::OP_PLACE;
                    cmd.respond = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[src/mhpq_dp.sv]
// mhpq_dp: heap datapath, count and position registers, moving word, result registers
// depends on mhpq_pkg and mhpq_ram

module mhpq_dp #(
    parameter int CAPACITY = 128
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic signed [mhpq_pkg::DATA_W-1:0] value,
    input  mhpq_pkg::ctrl_cmd_t               cmd,
    output mhpq_pkg::dp_stat_t                stat,
    output logic                              done,
    output logic [1:0]                        status,
    output logic signed [mhpq_pkg::DATA_W-1:0] removed_value,
    output logic [mhpq_pkg::COUNT_W-1:0]      entry_count,
    output logic signed [mhpq_pkg::DATA_W-1:0] max_value
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int DW = mhpq_pkg::DATA_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        pos_reg, pos_next;
    logic signed [DW-1:0] val_reg, val_next;
    logic signed [DW-1:0] root_reg, root_next;
    logic signed [DW-1:0] removed_reg, removed_next;
    mhpq_pkg::status_t    status_reg, status_next;
    logic                 done_reg;

    logic                 we;
    logic [AW-1:0]        waddr;
    logic signed [DW-1:0] wdata;
    logic [AW-1:0]        raddr_a, raddr_b;
    logic signed [DW-1:0] rdata_a, rdata_b;

    logic [CW:0]          left_pos;
    logic [CW-1:0]        pos_m1, count_m1, parent_pos, parent_m1;
    logic signed [DW-1:0] best_lr;
    logic [CW+7:0]        count_wide;

    mhpq_ram #(
        .WIDTH (DW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    assign left_pos   = {pos_reg, 1'b0};
    assign pos_m1     = pos_reg - ONE_C;
    assign count_m1   = count_reg - ONE_C;
    assign parent_pos = pos_reg >> 1;
    assign parent_m1  = parent_pos - ONE_C;

    // status to the sequencer
    assign stat.count_zero    = (count_reg == '0);
    assign stat.full          = (count_reg >= CAP_C);
    assign stat.at_root       = (pos_reg == ONE_C);
    assign stat.val_gt_parent = (val_reg > rdata_a);
    assign stat.leaf          = (left_pos > {1'b0, count_reg});
    assign stat.left_wins     = (rdata_a > val_reg);
    assign best_lr            = stat.left_wins ? rdata_a : val_reg;
    assign stat.right_wins    = (left_pos < {1'b0, count_reg}) && (rdata_b > best_lr);

    always_comb
    begin
        we      = 1'b0;
        waddr   = pos_m1[AW-1:0];
        wdata   = val_reg;
        raddr_a = left_pos[AW-1:0] - AW'(1);
        raddr_b = left_pos[AW-1:0];
        case (cmd.op)
            mhpq_pkg::OP_REM:     raddr_a = count_m1[AW-1:0];
            mhpq_pkg::OP_UP_READ: raddr_a = parent_m1[AW-1:0];
            mhpq_pkg::OP_PLACE:   we = 1'b1;
            mhpq_pkg::OP_UP_MOVE:
            begin
                we    = 1'b1;
                wdata = rdata_a;
            end
            mhpq_pkg::OP_DN_LEFT:
            begin
                we    = 1'b1;
                wdata = rdata_a;
            end
            mhpq_pkg::OP_DN_RIGHT:
            begin
                we    = 1'b1;
                wdata = rdata_b;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        count_next   = count_reg;
        pos_next     = pos_reg;
        val_next     = val_reg;
        removed_next = removed_reg;
        status_next  = status_reg;
        root_next    = (we && (waddr == '0)) ? wdata : root_reg;
        case (cmd.op)
            mhpq_pkg::OP_INS:
            begin
                val_next     = value;
                count_next   = count_reg + ONE_C;
                pos_next     = count_reg + ONE_C;
                removed_next = '0;
            end
            mhpq_pkg::OP_REM:
            begin
                removed_next = root_reg;
                count_next   = count_m1;
            end
            mhpq_pkg::OP_REJECT:  removed_next = '0;
            mhpq_pkg::OP_UP_MOVE: pos_next = parent_pos;
            mhpq_pkg::OP_LAST_LOAD:
            begin
                val_next = rdata_a;
                pos_next = ONE_C;
            end
            mhpq_pkg::OP_DN_LEFT:  pos_next = left_pos[CW-1:0];
            mhpq_pkg::OP_DN_RIGHT: pos_next = left_pos[CW-1:0] + ONE_C;
            default:
            begin
                pos_next = pos_reg;
            end
        endcase
        if (cmd.respond)
        begin
            status_next = cmd.code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= cmd.respond;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        val_reg     <= val_next;
        root_reg    <= root_next;
        removed_reg <= removed_next;
        status_reg  <= status_next;
    end

    assign count_wide    = {8'b0, count_reg};
    assign done          = done_reg;
    assign status        = status_reg;
    assign removed_value = removed_reg;
    assign entry_count   = count_wide[mhpq_pkg::COUNT_W-1:0];
    assign max_value     = (count_reg == '0) ? '0 : root_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_C)
        else $error("entry count above capacity");

    a_write_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> ({1'b0, waddr} < {1'b0, count_reg}))
        else $error("write beyond last entry");

endmodule
